### design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check on the rising edge, switched off during reset.
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Same check written as antecedent and consequent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

### design/smpose_pkg.sv
// Package for the square marker pose block: constants, register map, status codes.
`timescale 1ns / 1ps
package smpose_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int MARKER_W = 24;
  localparam int SENSOR_W = 20;
  localparam int DIM_W    = 13;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Diagonal lengths carry this many fraction bits.
  localparam int DIAG_FRAC = 14;

  // sqrt(2) in Q.30
  localparam int SQRT2_W = 31;
  localparam logic [SQRT2_W-1:0] SQRT2_Q30 = 31'd1518500250;

  localparam logic [MARKER_W-1:0] MARKER_RST = 24'd65536;
  localparam logic [SENSOR_W-1:0] SENSOR_RST = 20'd75674;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    REG_MARKER_SIZE  = 2'd0,
    REG_SENSOR_SIZE  = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

endpackage

### design/square_marker_pose_from_corners.sv
// Square marker pose from four pixel corners: top level, fully pipelined.
//
// Usage: drive the four corners and pulse start; busy stays low, so an item
// is taken on every cycle start is high. Each item gives one result, shown
// on pos_x, pos_y, pos_z and status for exactly one cycle with done high.
// The receiver cannot stall; results leave in the order items came in.
// Throughput is one item per cycle. The pipeline runs through, in order:
// two one-bit-per-stage square roots side by side (COORD_BITS+15 stages),
// the one-bit-per-stage ratio divider (42 stages), three multiply/round
// stages and the 32-stage depth divider. The user must write registers
// over the APB port only while no item is in flight; the block itself
// does not enforce it. Reset clears every valid bit and loads the
// register defaults; there is no clearing pass and no memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module square_marker_pose_from_corners #(
  parameter int COORD_BITS = smpose_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = smpose_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         corner0_x,
  input  logic [COORD_BITS-1:0]         corner0_y,
  input  logic [COORD_BITS-1:0]         corner1_x,
  input  logic [COORD_BITS-1:0]         corner1_y,
  input  logic [COORD_BITS-1:0]         corner2_x,
  input  logic [COORD_BITS-1:0]         corner2_y,
  input  logic [COORD_BITS-1:0]         corner3_x,
  input  logic [COORD_BITS-1:0]         corner3_y,
  output logic                          done,
  output logic signed [31:0]            pos_x,
  output logic signed [31:0]            pos_y,
  output logic [31:0]                   pos_z,
  output logic [1:0]                    status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smpose_pkg::ADDR_W-1:0] paddr,
  input  logic [smpose_pkg::DATA_W-1:0] pwdata,
  output logic [smpose_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import smpose_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int DW    = 2 * CB + 1;
  localparam int SRW   = (DW + 2 * DIAG_FRAC + 1) / 2;
  localparam int RADW  = 2 * SRW;
  localparam int REMW  = SRW + 2;
  localparam int DQW   = SRW + 1;
  localparam int PW    = SQRT2_W + MARKER_W;
  localparam int NW1   = PW + 1;
  localparam int QW1   = NW1 - DIAG_FRAC;
  localparam int SUMW  = CB + 2;
  localparam int OW    = ((SUMW > DIM_W + 1) ? SUMW : DIM_W + 1) + 1;
  localparam int MW    = OW - 1;
  localparam int RL    = QW1 / 2;
  localparam int RH    = QW1 - RL;
  localparam int PXW   = MW + QW1;
  localparam int SH    = 33 - FB;
  localparam int MWID  = PXW + 1 - SH;
  localparam int CWID  = (MWID > 33) ? MWID : 33;
  localparam int NUMW  = QW1 + DIM_W;
  localparam int KP    = (FB > 15) ? FB - 15 : 0;
  localparam int KN    = (FB < 15) ? 15 - FB : 0;
  localparam int N2W   = NUMW + KP + 1;
  localparam int DNW   = SENSOR_W + KN;
  localparam int TW    = N2W - 32;
  localparam int EW    = (TW > DNW) ? TW : DNW;
  localparam int QZ    = 32;
  localparam int LAT   = SRW + QW1 + 39;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [SRW-1:0]  root;
  } lane_t;

  typedef struct packed {
    lane_t          l0;
    lane_t          l1;
    logic           negx;
    logic           negy;
    logic [MW-1:0]  magx;
    logic [MW-1:0]  magy;
  } sq_t;

  typedef struct packed {
    logic [DQW-1:0] rem;
    logic [QW1-1:0] nq;
    logic [DQW-1:0] dq;
    logic           deg;
    logic           negx;
    logic           negy;
    logic [MW-1:0]  magx;
    logic [MW-1:0]  magy;
  } da_t;

  typedef struct packed {
    logic [DNW-1:0] rem;
    logic [QZ-1:0]  nq;
    logic [DNW-1:0] den;
    logic           ovf;
    logic [31:0]    px;
    logic [31:0]    py;
    logic           sat;
    logic           deg;
  } dv_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } scaled_t;

  // ---------------- configuration ----------------
  logic [MARKER_W-1:0] marker_size;
  logic [SENSOR_W-1:0] sensor_size;
  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic [PW-1:0]       p_size;
  cfg_reg_t            cfg_sel;

  assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_size  <= MARKER_RST;
      sensor_size  <= SENSOR_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_sel)
        REG_MARKER_SIZE:  marker_size  <= pwdata[MARKER_W-1:0];
        REG_SENSOR_SIZE:  sensor_size  <= pwdata[SENSOR_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MARKER_SIZE:  prdata = DATA_W'(marker_size);
      REG_SENSOR_SIZE:  prdata = DATA_W'(sensor_size);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // sqrt(2) * marker size, Q.46; the user must keep config static while items are in flight (not enforced)
  always_ff @(posedge clk) begin
    p_size <= PW'(SQRT2_Q30) * PW'(marker_size);
  end

  // ---------------- step functions ----------------
  function automatic lane_t sqrt_step(lane_t a);
    lane_t           r;
    logic [REMW+1:0] trial;
    logic [REMW+1:0] test;
    trial  = {a.rem, a.rad[RADW-1 -: 2]};
    test   = (REMW + 2)'({a.root, 2'b01});
    r.rad  = a.rad << 2;
    if (trial >= test) begin
      r.rem  = REMW'(trial - test);
      r.root = {a.root[SRW-2:0], 1'b1};
    end else begin
      r.rem  = REMW'(trial);
      r.root = {a.root[SRW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sq_t sq_adv(sq_t a);
    sq_t r;
    r    = a;
    r.l0 = sqrt_step(a.l0);
    r.l1 = sqrt_step(a.l1);
    return r;
  endfunction

  function automatic da_t da_adv(da_t a);
    da_t          r;
    logic [DQW:0] trial;
    r     = a;
    trial = {a.rem, a.nq[QW1-1]};
    if (trial >= {1'b0, a.dq}) begin
      r.rem = DQW'(trial - {1'b0, a.dq});
      r.nq  = {a.nq[QW1-2:0], 1'b1};
    end else begin
      r.rem = DQW'(trial);
      r.nq  = {a.nq[QW1-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_adv(dv_t a);
    dv_t          r;
    logic [DNW:0] trial;
    r     = a;
    trial = {a.rem, a.nq[QZ-1]};
    if (trial >= {1'b0, a.den}) begin
      r.rem = DNW'(trial - {1'b0, a.den});
      r.nq  = {a.nq[QZ-2:0], 1'b1};
    end else begin
      r.rem = DNW'(trial);
      r.nq  = {a.nq[QZ-2:0], 1'b0};
    end
    return r;
  endfunction

  // round the magnitude half up, apply sign, saturate to signed 32 bits
  function automatic scaled_t scale_sat(logic neg, logic [PXW-1:0] prod);
    scaled_t       r;
    logic [PXW:0]  pr;
    logic [CWID-1:0] m;
    pr = (PXW + 1)'(prod) + ((PXW + 1)'(1) << (SH - 1));
    m  = CWID'(MWID'(pr >> SH));
    r.sat = 1'b0;
    if (neg) begin
      if (m > CWID'(33'h0_8000_0000)) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'(CWID'(0) - m);
      end
    end else if (m > CWID'(32'h7FFF_FFFF)) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else begin
      r.val = 32'(m);
    end
    return r;
  endfunction

  // ---------------- input stage ----------------
  logic signed [CB:0]     dx0, dy0, dx1, dy1;
  logic signed [2*CB+1:0] sqx0, sqy0, sqx1, sqy1;
  logic [DW-1:0]          d0, d1;
  logic [SUMW-1:0]        sx, sy;
  logic signed [OW-1:0]   offx, offy;
  sq_t                    sq_in;

  always_comb begin
    dx0  = $signed({1'b0, corner0_x}) - $signed({1'b0, corner2_x});
    dy0  = $signed({1'b0, corner0_y}) - $signed({1'b0, corner2_y});
    dx1  = $signed({1'b0, corner1_x}) - $signed({1'b0, corner3_x});
    dy1  = $signed({1'b0, corner1_y}) - $signed({1'b0, corner3_y});
    sqx0 = dx0 * dx0;
    sqy0 = dy0 * dy0;
    sqx1 = dx1 * dx1;
    sqy1 = dy1 * dy1;
    d0   = DW'(sqx0 + sqy0);
    d1   = DW'(sqx1 + sqy1);
    sx   = SUMW'(corner0_x) + SUMW'(corner1_x) + SUMW'(corner2_x) + SUMW'(corner3_x);
    sy   = SUMW'(corner0_y) + SUMW'(corner1_y) + SUMW'(corner2_y) + SUMW'(corner3_y);
    // offsets in quarter pixels
    offx = $signed(OW'(sx)) - $signed(OW'({image_width[DIM_W-1:1], 2'b00}));
    offy = $signed(OW'(sy)) - $signed(OW'({image_height[DIM_W-1:1], 2'b00}));
    sq_in.l0.rad  = RADW'(d0) << (2 * DIAG_FRAC);
    sq_in.l0.rem  = '0;
    sq_in.l0.root = '0;
    sq_in.l1.rad  = RADW'(d1) << (2 * DIAG_FRAC);
    sq_in.l1.rem  = '0;
    sq_in.l1.root = '0;
    sq_in.negx    = offx[OW-1];
    sq_in.negy    = offy[OW-1];
    sq_in.magx    = MW'(offx[OW-1] ? -offx : offx);
    sq_in.magy    = MW'(offy[OW-1] ? -offy : offy);
  end

  // ---------------- pipeline registers ----------------
  sq_t              sq [SRW+1];
  da_t              da [QW1+1];
  dv_t              dv [QZ+1];
  logic [SRW:0]     sq_vld;
  logic [QW1:0]     da_vld;
  logic [2:0]       m_vld;
  logic [QZ:0]      dv_vld;

  logic [MW+RL-1:0]    pxl, pyl;
  logic [MW+RH-1:0]    pxh, pyh;
  logic [RL+DIM_W-1:0] wl;
  logic [RH+DIM_W-1:0] wh;
  logic                m1_deg, m1_negx, m1_negy;
  logic [PXW-1:0]      m2_px, m2_py;
  logic [NUMW-1:0]     m2_num;
  logic                m2_deg, m2_negx, m2_negy;
  logic [31:0]         m3_px, m3_py;
  logic                m3_sat, m3_deg;
  logic [N2W-1:0]      m3_n2;
  logic [DNW-1:0]      m3_den;

  logic [DQW-1:0]      dq_sum;
  logic [NW1-1:0]      n1;
  logic [QW1-1:0]      rq;
  scaled_t             scx, scy;
  logic [DNW-1:0]      den_c;
  logic [TW-1:0]       n2_top;

  always_comb begin
    dq_sum = DQW'(sq[SRW].l0.root) + DQW'(sq[SRW].l1.root);
    n1     = NW1'(p_size) + NW1'(dq_sum >> 1);
    rq     = da[QW1].nq;
    scx    = scale_sat(m2_negx, m2_px);
    scy    = scale_sat(m2_negy, m2_py);
    den_c  = DNW'(sensor_size) << KN;
    n2_top = TW'(m3_n2 >> 32);
  end

  always_ff @(posedge clk) begin
    sq[0] <= sq_in;
    for (int j = 0; j < SRW; j++) sq[j+1] <= sq_adv(sq[j]);

    da[0].dq   <= dq_sum;
    da[0].deg  <= (dq_sum == '0);
    da[0].rem  <= DQW'(n1[NW1-1:QW1]);
    da[0].nq   <= n1[QW1-1:0];
    da[0].negx <= sq[SRW].negx;
    da[0].negy <= sq[SRW].negy;
    da[0].magx <= sq[SRW].magx;
    da[0].magy <= sq[SRW].magy;
    for (int j = 0; j < QW1; j++) da[j+1] <= da_adv(da[j]);

    // ratio split in halves keeps each product narrow
    pxl     <= da[QW1].magx * rq[RL-1:0];
    pxh     <= da[QW1].magx * rq[QW1-1:RL];
    pyl     <= da[QW1].magy * rq[RL-1:0];
    pyh     <= da[QW1].magy * rq[QW1-1:RL];
    wl      <= rq[RL-1:0] * image_width;
    wh      <= rq[QW1-1:RL] * image_width;
    m1_deg  <= da[QW1].deg;
    m1_negx <= da[QW1].negx;
    m1_negy <= da[QW1].negy;

    m2_px   <= PXW'(pxl) + (PXW'(pxh) << RL);
    m2_py   <= PXW'(pyl) + (PXW'(pyh) << RL);
    m2_num  <= NUMW'(wl) + (NUMW'(wh) << RL);
    m2_deg  <= m1_deg;
    m2_negx <= m1_negx;
    m2_negy <= m1_negy;

    m3_px  <= scx.val;
    m3_py  <= scy.val;
    m3_sat <= scx.sat | scy.sat;
    m3_deg <= m2_deg;
    m3_n2  <= (N2W'(m2_num) << KP) + N2W'(den_c >> 1);
    m3_den <= den_c;

    // quotient overflows 32 bits exactly when the top part reaches the divisor
    dv[0].ovf <= EW'(n2_top) >= EW'(m3_den);
    dv[0].rem <= DNW'(EW'(n2_top));
    dv[0].nq  <= m3_n2[QZ-1:0];
    dv[0].den <= m3_den;
    dv[0].px  <= m3_px;
    dv[0].py  <= m3_py;
    dv[0].sat <= m3_sat;
    dv[0].deg <= m3_deg;
    for (int j = 0; j < QZ; j++) dv[j+1] <= dv_adv(dv[j]);

    if (dv[QZ].deg) begin
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      status <= STATUS_DEGEN;
    end else begin
      pos_x  <= $signed(dv[QZ].px);
      pos_y  <= $signed(dv[QZ].py);
      pos_z  <= dv[QZ].ovf ? 32'hFFFF_FFFF : dv[QZ].nq;
      status <= (dv[QZ].sat || dv[QZ].ovf) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
      da_vld <= '0;
      m_vld  <= '0;
      dv_vld <= '0;
      done   <= 1'b0;
    end else begin
      sq_vld <= {sq_vld[SRW-1:0], start && !busy};
      da_vld <= {da_vld[QW1-1:0], sq_vld[SRW]};
      m_vld  <= {m_vld[1:0], da_vld[QW1]};
      dv_vld <= {dv_vld[QZ-1:0], m_vld[2]};
      done   <= dv_vld[QZ];
    end
  end

  // ---------------- checks ----------------
  `ASSERT_IMPLY(a_latency, clk, rst, start && !busy, ##LAT done)
  `ASSERT_IMPLY(a_degen_zero, clk, rst, done && status == STATUS_DEGEN,
                pos_x == 0 && pos_y == 0 && pos_z == 0)
  `ASSERT_IMPLY(a_diag_floor, clk, rst, da_vld[0] && !da[0].deg,
                da[0].dq >= (DQW'(1) << DIAG_FRAC))
  `ASSERT_IMPLY(a_status_code, clk, rst, done,
                status == STATUS_OK || status == STATUS_DEGEN || status == STATUS_SAT)

endmodule
